[design/slp_pkg.sv]
// shared types, codes and helpers for the stepper lift positioner
`default_nettype none
package slp_pkg;

  // fixed field widths
  localparam int unsigned KNOB_W  = 24;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned HOLD_W  = 10;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_X2   = 1'd1;

  // configuration reset values
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 10'd150;
  localparam logic [SCALE_W-1:0] STEPS_X2_RST   = 8'd5;

  // external mode codes
  localparam logic [CODE_W-1:0] MC_IDLE     = 4'd0;
  localparam logic [CODE_W-1:0] MC_SEEK     = 4'd1;
  localparam logic [CODE_W-1:0] MC_HOLD_UP  = 4'd2;
  localparam logic [CODE_W-1:0] MC_HOLD_DN  = 4'd3;
  localparam logic [CODE_W-1:0] MC_JOG_UP   = 4'd4;
  localparam logic [CODE_W-1:0] MC_JOG_DN   = 4'd5;
  localparam logic [CODE_W-1:0] MC_HOME_TOP = 4'd6;
  localparam logic [CODE_W-1:0] MC_HOME_BOT = 4'd7;
  localparam logic [CODE_W-1:0] MC_RELEASE  = 4'd8;

  // controller state, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE     = 9'b000000001,
    MODE_SEEK     = 9'b000000010,
    MODE_HOLD_UP  = 9'b000000100,
    MODE_HOLD_DN  = 9'b000001000,
    MODE_JOG_UP   = 9'b000010000,
    MODE_JOG_DN   = 9'b000100000,
    MODE_HOME_TOP = 9'b001000000,
    MODE_HOME_BOT = 9'b010000000,
    MODE_RELEASE  = 9'b100000000
  } mode_t;

  // one tick item
  typedef struct packed {
    logic signed [KNOB_W-1:0] knob_clicks;
    logic                     knob_pressed;
    logic                     up_pressed;
    logic                     down_pressed;
    logic                     top_clear;
    logic                     bottom_clear;
  } tick_t;

  // one result item
  typedef struct packed {
    logic                    step_pulse;
    logic                    step_down;
    logic signed [OUT_W-1:0] position_steps;
    logic [CODE_W-1:0]       mode_code;
  } res_t;

  // state to external mode code
  function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:     c = MC_IDLE;
      MODE_SEEK:     c = MC_SEEK;
      MODE_HOLD_UP:  c = MC_HOLD_UP;
      MODE_HOLD_DN:  c = MC_HOLD_DN;
      MODE_JOG_UP:   c = MC_JOG_UP;
      MODE_JOG_DN:   c = MC_JOG_DN;
      MODE_HOME_TOP: c = MC_HOME_TOP;
      MODE_HOME_BOT: c = MC_HOME_BOT;
      MODE_RELEASE:  c = MC_RELEASE;
      default:       c = MC_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[design/stepper_lift_positioner.sv]
// top level: tick input register, controller, result register, config registers
//
//  channel | direction | payload                                         | handshake
//  in_     | input     | knob_clicks, knob/up/down pressed, top/bot clear | in_valid / in_ready
//  out_    | output    | step_pulse, step_down, position_steps, mode_code | out_valid / out_ready
//  cfg_    | input     | cfg_index, cfg_data                             | cfg_valid / cfg_ready
//
// one transaction per clock sustained while out_ready is high; a transaction passes through
// the input register, then decision logic into the result register
// the one-tick decision path between the two registers holds a multiply, a saturate and a compare
// a stalled result holds the result register; the input register still takes one more
// transaction, then in_ready drops until the result is taken
// reset is synchronous and active low; cfg_ready is always high
`default_nettype none
module stepper_lift_positioner #(
  parameter int unsigned POS_WIDTH = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [slp_pkg::KNOB_W-1:0]   in_knob_clicks,
  input  wire logic                                in_knob_pressed,
  input  wire logic                                in_up_pressed,
  input  wire logic                                in_down_pressed,
  input  wire logic                                in_top_clear,
  input  wire logic                                in_bottom_clear,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_step_pulse,
  output logic                                     out_step_down,
  output logic signed [slp_pkg::OUT_W-1:0]         out_position_steps,
  output logic [slp_pkg::CODE_W-1:0]               out_mode_code,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [slp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [slp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                            in_vld_r;
  slp_pkg::tick_t                  in_item_r;
  logic                            out_vld_r;
  slp_pkg::res_t                   out_res_r;
  slp_pkg::res_t                   res;
  logic [slp_pkg::HOLD_W-1:0]      hold_ticks_r;
  logic [slp_pkg::SCALE_W-1:0]     scale_r;
  logic                            advance;
  logic                            fire;
  logic                            in_take;

  // stage control
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= slp_pkg::HOLD_TICKS_RST;
      scale_r      <= slp_pkg::STEPS_X2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slp_pkg::REG_HOLD_TICKS: hold_ticks_r <= cfg_data;
        slp_pkg::REG_STEPS_X2:   scale_r      <= cfg_data[slp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.knob_clicks  <= in_knob_clicks;
      in_item_r.knob_pressed <= in_knob_pressed;
      in_item_r.up_pressed   <= in_up_pressed;
      in_item_r.down_pressed <= in_down_pressed;
      in_item_r.top_clear    <= in_top_clear;
      in_item_r.bottom_clear <= in_bottom_clear;
    end
  end

  // decision logic and controller state
  slp_ctrl #(.POS_WIDTH(POS_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (fire),
    .tick       (in_item_r),
    .hold_ticks (hold_ticks_r),
    .scale      (scale_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_step_pulse     = out_res_r.step_pulse;
  assign out_step_down      = out_res_r.step_down;
  assign out_position_steps = out_res_r.position_steps;
  assign out_mode_code      = out_res_r.mode_code;

  // no direction flag without a step
  a_dir_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.step_pulse |-> !out_res_r.step_down)
    else $error("step direction set without a step");

  // hold and release wait never issue a step
  a_no_step_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.step_pulse |->
      (out_res_r.mode_code != slp_pkg::MC_HOLD_UP) &&
      (out_res_r.mode_code != slp_pkg::MC_HOLD_DN) &&
      (out_res_r.mode_code != slp_pkg::MC_RELEASE))
    else $error("step issued while waiting");

  // every processed tick produces a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed tick lost its result");

  // a held input tick is not dropped
  a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r)
    else $error("pending tick dropped");

endmodule
`default_nettype wire

[design/slp_target.sv]
// knob count to step target: -(scale * clicks) / 2, truncated, saturated
`default_nettype none
module slp_target #(
  parameter int unsigned POS_WIDTH = 24
) (
  input  wire logic signed [slp_pkg::KNOB_W-1:0]  clicks,
  input  wire logic [slp_pkg::SCALE_W-1:0]        scale,
  output logic signed [POS_WIDTH-1:0]             target
);

  localparam logic signed [32:0] PMAX = (33'sd1 <<< (POS_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] PMIN = -PMAX - 33'sd1;

  logic signed [32:0] prod;
  logic signed [32:0] neg;
  logic signed [32:0] half;
  logic signed [32:0] sat;

  // product and its negation both fit in 32 bits; they are held in 33
  always_comb begin
    prod = 33'($signed({1'b0, scale})) * 33'(clicks);
    neg  = -prod;
    // round toward zero before the arithmetic shift
    half = (neg + $signed({32'd0, neg[32]})) >>> 1;
    if (half > PMAX) begin
      sat = PMAX;
    end else if (half < PMIN) begin
      sat = PMIN;
    end else begin
      sat = half;
    end
    target = POS_WIDTH'(sat);
  end

endmodule
`default_nettype wire

[design/slp_ctrl.sv]
// mode state machine and position state, one tick per enabled cycle
`default_nettype none
module slp_ctrl #(
  parameter int unsigned POS_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          tick_en,
  input  wire slp_pkg::tick_t                tick,
  input  wire logic [slp_pkg::HOLD_W-1:0]    hold_ticks,
  input  wire logic [slp_pkg::SCALE_W-1:0]   scale,
  output slp_pkg::res_t                      res
);

  localparam logic signed [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  slp_pkg::mode_t mode_r, mode_nxt;
  logic signed [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic signed [POS_WIDTH-1:0] target_r, target_nxt;
  logic [slp_pkg::KNOB_W-1:0] offset_r, offset_nxt;
  logic [slp_pkg::KNOB_W-1:0] last_r, last_nxt;
  logic [slp_pkg::HOLD_W-1:0] hold_cnt_r, hold_cnt_nxt;

  logic [slp_pkg::KNOB_W-1:0] clicks;
  logic signed [POS_WIDTH-1:0] knob_target;
  logic signed [POS_WIDTH-1:0] pos_up, pos_dn;
  logic ok_up, ok_dn, goup, pulse, sdown;

  // knob count relative to the last zeroing
  assign clicks = tick.knob_clicks - offset_r;

  slp_target #(.POS_WIDTH(POS_WIDTH)) u_target (
    .clicks (clicks),
    .scale  (scale),
    .target (knob_target)
  );

  // saturating single steps and their gating
  assign pos_up = (pos_r == PMAX) ? pos_r : pos_r + POS_WIDTH'(1);
  assign pos_dn = (pos_r == PMIN) ? pos_r : pos_r - POS_WIDTH'(1);
  assign ok_up  = tick.top_clear && !tick.knob_pressed;
  assign ok_dn  = tick.bottom_clear && !tick.knob_pressed;
  assign goup   = target_r > pos_r;

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    target_nxt   = target_r;
    offset_nxt   = offset_r;
    last_nxt     = last_r;
    hold_cnt_nxt = hold_cnt_r;
    pulse        = 1'b0;
    sdown        = 1'b0;
    unique case (mode_r)
      slp_pkg::MODE_IDLE: begin
        if (clicks != last_r) begin
          last_nxt   = clicks;
          target_nxt = knob_target;
          if (knob_target != pos_r) begin
            mode_nxt = slp_pkg::MODE_SEEK;
          end
        end else if (tick.knob_pressed) begin
          pos_nxt    = '0;
          offset_nxt = tick.knob_clicks;
          last_nxt   = '0;
        end else if (tick.up_pressed) begin
          mode_nxt     = slp_pkg::MODE_HOLD_UP;
          hold_cnt_nxt = '0;
        end else if (tick.down_pressed) begin
          mode_nxt     = slp_pkg::MODE_HOLD_DN;
          hold_cnt_nxt = '0;
        end
      end
      slp_pkg::MODE_SEEK: begin
        if (pos_r == target_r) begin
          mode_nxt = slp_pkg::MODE_IDLE;
        end else if (goup ? ok_up : ok_dn) begin
          pulse   = 1'b1;
          sdown   = !goup;
          pos_nxt = goup ? pos_up : pos_dn;
          if ((goup ? pos_up : pos_dn) == target_r) begin
            mode_nxt = slp_pkg::MODE_IDLE;
          end
        end else begin
          mode_nxt = slp_pkg::MODE_IDLE;
        end
      end
      slp_pkg::MODE_HOLD_UP: begin
        if (hold_cnt_r < hold_ticks) begin
          hold_cnt_nxt = hold_cnt_r + 1'b1;
        end else if (tick.up_pressed) begin
          mode_nxt = slp_pkg::MODE_JOG_UP;
        end else if (!pos_r[POS_WIDTH-1]) begin
          mode_nxt = slp_pkg::MODE_HOME_TOP;
        end else begin
          target_nxt = '0;
          mode_nxt   = slp_pkg::MODE_SEEK;
        end
      end
      slp_pkg::MODE_HOLD_DN: begin
        if (hold_cnt_r < hold_ticks) begin
          hold_cnt_nxt = hold_cnt_r + 1'b1;
        end else if (tick.down_pressed) begin
          mode_nxt = slp_pkg::MODE_JOG_DN;
        end else if (pos_r[POS_WIDTH-1] || (pos_r == '0)) begin
          mode_nxt = slp_pkg::MODE_HOME_BOT;
        end else begin
          target_nxt = '0;
          mode_nxt   = slp_pkg::MODE_SEEK;
        end
      end
      slp_pkg::MODE_JOG_UP: begin
        if (!tick.up_pressed) begin
          mode_nxt = slp_pkg::MODE_IDLE;
        end else if (ok_up) begin
          pulse   = 1'b1;
          pos_nxt = pos_up;
        end
      end
      slp_pkg::MODE_JOG_DN: begin
        if (!tick.down_pressed) begin
          mode_nxt = slp_pkg::MODE_IDLE;
        end else if (ok_dn) begin
          pulse   = 1'b1;
          sdown   = 1'b1;
          pos_nxt = pos_dn;
        end
      end
      slp_pkg::MODE_HOME_TOP: begin
        if (ok_up) begin
          pulse   = 1'b1;
          pos_nxt = pos_up;
        end else begin
          mode_nxt = slp_pkg::MODE_RELEASE;
        end
      end
      slp_pkg::MODE_HOME_BOT: begin
        if (ok_dn) begin
          pulse   = 1'b1;
          sdown   = 1'b1;
          pos_nxt = pos_dn;
        end else begin
          mode_nxt = slp_pkg::MODE_RELEASE;
        end
      end
      slp_pkg::MODE_RELEASE: begin
        if (!tick.knob_pressed) begin
          mode_nxt = slp_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = slp_pkg::MODE_IDLE;
      end
    endcase
  end

  // result of this tick
  always_comb begin
    res.step_pulse     = pulse;
    res.step_down      = sdown;
    res.position_steps = slp_pkg::OUT_W'(pos_nxt);
    res.mode_code      = slp_pkg::mode_code(mode_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= slp_pkg::MODE_IDLE;
      pos_r      <= '0;
      target_r   <= '0;
      offset_r   <= '0;
      last_r     <= '0;
      hold_cnt_r <= '0;
    end else if (tick_en) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      target_r   <= target_nxt;
      offset_r   <= offset_nxt;
      last_r     <= last_nxt;
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

endmodule
`default_nettype wire
